FILE: rtl/fenv_pkg.sv
// Shared types, widths and codes for the fade envelope generator.
package fenv_pkg;

  localparam int TIME_W      = 32;
  localparam int LEVEL_W     = 16;
  localparam int SPEED_W     = 16;
  localparam int SPEED_FRAC  = 8;
  localparam int MODE_W      = 2;
  localparam int PHASE_W     = 3;
  localparam int PROD_W      = TIME_W + LEVEL_W;
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 32;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_FIELD_W = LEVEL_W + PHASE_W + 3;
  localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

  localparam logic [MODE_W-1:0]  MODE_AUTO    = 2'd0;
  localparam logic [MODE_W-1:0]  MODE_OFF     = 2'd1;
  localparam logic [LEVEL_W-1:0] TARGET_RESET = 16'd4096;
  localparam logic [SPEED_W-1:0] SPEED_RESET  = 16'd256;

  typedef enum logic [0:0] {
    REQ_START = 1'b0,
    REQ_TICK  = 1'b1
  } req_t;

  typedef enum logic [PHASE_W-1:0] {
    PH_IDLE   = 3'd0,
    PH_IN     = 3'd1,
    PH_STEADY = 3'd2,
    PH_OUT    = 3'd3,
    PH_STOP   = 3'd4
  } phase_t;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_FADE_IN   = 3'd0,
    REG_FADE_OUT  = 3'd1,
    REG_TARGET    = 3'd2,
    REG_HOLD      = 3'd3,
    REG_TOTAL     = 3'd4,
    REG_SPEED     = 3'd5,
    REG_MODE      = 3'd6,
    REG_MANUAL    = 3'd7
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE     = 3'd0,
    ST_SCALE    = 3'd1,
    ST_ADVANCE  = 3'd2,
    ST_EVAL     = 3'd3,
    ST_RAMP_MUL = 3'd4,
    ST_DIV_LOAD = 3'd5,
    ST_DIV_RUN  = 3'd6,
    ST_DONE     = 3'd7
  } ctrl_state_t;

  typedef struct packed {
    logic take_in;
    logic scale;
    logic advance;
    logic eval;
    logic ramp_mul;
    logic div_start;
    logic take_q;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic auto_tick;
    logic need_div;
    logic div_busy;
  } stat_t;

endpackage

FILE: rtl/fade_envelope_generator_core.sv
// Top level of the fade envelope generator: stream ports, config port, controller, datapath.
//
//  channel   | direction | transfer content
//  s_axis    | in        | tuser = req_type, tdata = delta_time
//  m_axis    | out       | tdata = level, phase, still_active, start_accepted, applies
//  cfg       | in        | write enable, register index, write data
//
// A start item or any item in manual mode goes from idle straight to the final state.
// A tick passes through the scale, advance and evaluate states, plus multiply, divider
// load and divide states (one quotient bit per cycle) when a ramp level is computed.
// Reset (rst, synchronous) clears the envelope to idle and the registers to defaults.
// A new item is taken while the previous result waits in the output register;
// a stalled output holds the next result in the controller's final state.
module fade_envelope_generator_core
  import fenv_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // [31:0] delta_time
  input  logic                   s_axis_tuser,  // [0] req_type
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // [15:0] level, [18:16] phase, [19] still_active, [20] start_accepted, [21] applies
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input  logic                   cfg_we,
  input  logic [CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  cmd_t  cmd;
  stat_t stat;

  fenv_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  fenv_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_req    (s_axis_tuser),
    .in_delta  (s_axis_tdata[TIME_W-1:0]),
    .cmd       (cmd),
    .stat      (stat),
    .out_data  (m_axis_tdata)
  );

endmodule

FILE: rtl/fenv_div.sv
// Restoring divider, one quotient bit per cycle, 16-bit saturated quotient.
module fenv_div
  import fenv_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [PROD_W-1:0]  dividend,
  input  logic [TIME_W-1:0]  divisor,
  output logic               busy,
  output logic [LEVEL_W-1:0] quotient
);

  localparam int CNT_W = $clog2(LEVEL_W + 1);

  logic [CNT_W-1:0]   cnt;
  logic [TIME_W-1:0]  rem;
  logic [TIME_W-1:0]  den;
  logic [LEVEL_W-1:0] low;
  logic               sat;

  logic [TIME_W:0]    trial;
  logic [TIME_W:0]    diff;
  logic               ge;

  assign trial = {rem, low[LEVEL_W-1]};
  assign diff  = trial - {1'b0, den};
  assign ge    = trial >= {1'b0, den};
  assign busy  = cnt != '0;
  assign quotient = sat ? '1 : low;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= CNT_W'(LEVEL_W);
    end else if (busy) begin
      cnt <= cnt - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      // quotient overflows 16 bits exactly when the upper part reaches the divisor
      rem <= dividend[PROD_W-1:LEVEL_W];
      low <= dividend[LEVEL_W-1:0];
      den <= divisor;
      sat <= dividend[PROD_W-1:LEVEL_W] >= divisor;
    end else if (busy) begin
      rem <= ge ? diff[TIME_W-1:0] : trial[TIME_W-1:0];
      low <= {low[LEVEL_W-2:0], ge};
    end
  end

endmodule

FILE: rtl/fenv_ctrl.sv
// Sequencing state machine and stream handshakes.
module fenv_ctrl
  import fenv_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  output logic  out_valid,
  input  logic  out_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  ctrl_state_t state, state_next;
  logic        out_valid_next;
  logic        can_load;

  assign can_load = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = stat.auto_tick ? ST_SCALE : ST_DONE;
        end
      end
      ST_SCALE:    state_next = ST_ADVANCE;
      ST_ADVANCE:  state_next = ST_EVAL;
      ST_EVAL:     state_next = stat.need_div ? ST_RAMP_MUL : ST_DONE;
      ST_RAMP_MUL: state_next = ST_DIV_LOAD;
      ST_DIV_LOAD: state_next = ST_DIV_RUN;
      ST_DIV_RUN: begin
        if (!stat.div_busy) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (can_load) begin
          state_next = ST_IDLE;
        end
      end
      default:     state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd            = '0;
    in_ready       = 1'b0;
    out_valid_next = out_valid && !out_ready;
    case (state)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.take_in = in_valid;
      end
      ST_SCALE:    cmd.scale     = 1'b1;
      ST_ADVANCE:  cmd.advance   = 1'b1;
      ST_EVAL:     cmd.eval      = 1'b1;
      ST_RAMP_MUL: cmd.ramp_mul  = 1'b1;
      ST_DIV_LOAD: cmd.div_start = 1'b1;
      ST_DIV_RUN:  cmd.take_q    = !stat.div_busy;
      ST_DONE: begin
        // hold the result until the output register is free
        cmd.load_out = can_load;
        if (can_load) begin
          out_valid_next = 1'b1;
        end
      end
      default: ;
    endcase
  end

endmodule

FILE: rtl/fenv_dp.sv
// Datapath: registers, time scaling, phase evaluation, ramp multiply and divide.
module fenv_dp
  import fenv_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                   in_req,
  input  logic [TIME_W-1:0]      in_delta,
  input  cmd_t                   cmd,
  output stat_t                  stat,
  output logic [OUT_TDATA_W-1:0] out_data
);

  // configuration
  logic [TIME_W-1:0]  fade_in_time, fade_out_time, total_length;
  logic [LEVEL_W-1:0] target_level, manual_level;
  logic [SPEED_W-1:0] speed_factor;
  logic [MODE_W-1:0]  manual_mode;
  logic               hold_at_end;

  // envelope state
  phase_t             phase;
  logic [TIME_W-1:0]  elapsed;
  logic [LEVEL_W-1:0] level;
  logic               active;

  // working registers
  req_t               req;
  logic [TIME_W-1:0]  delta;
  logic [PROD_W-1:0]  prod;
  logic [TIME_W-1:0]  ramp_a;
  logic [TIME_W-1:0]  ramp_den;

  // evaluation results
  phase_t             ev_phase;
  logic [LEVEL_W-1:0] ev_level;
  logic               ev_active;
  logic               ev_div;
  logic               ev_clamp;
  logic [TIME_W-1:0]  ev_a;
  logic [TIME_W-1:0]  ev_den;
  logic [TIME_W:0]    edge_s;
  logic               to_out, to_stop;

  logic [PROD_W-SPEED_FRAC-1:0] inc;
  logic [PROD_W-SPEED_FRAC:0]   sum;
  logic [TIME_W-1:0]            elapsed_next;

  logic               div_busy;
  logic [LEVEL_W-1:0] div_q;

  logic                   auto;
  logic [LEVEL_W-1:0]     o_level;
  phase_t                 o_phase;
  logic                   o_active, o_acc, o_applies;

  assign auto = manual_mode == MODE_AUTO;

  always_ff @(posedge clk) begin
    if (rst) begin
      fade_in_time  <= '0;
      fade_out_time <= '0;
      target_level  <= TARGET_RESET;
      hold_at_end   <= 1'b0;
      total_length  <= '0;
      speed_factor  <= SPEED_RESET;
      manual_mode   <= MODE_AUTO;
      manual_level  <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_addr))
        REG_FADE_IN:  fade_in_time  <= cfg_wdata[TIME_W-1:0];
        REG_FADE_OUT: fade_out_time <= cfg_wdata[TIME_W-1:0];
        REG_TARGET:   target_level  <= cfg_wdata[LEVEL_W-1:0];
        REG_HOLD:     hold_at_end   <= cfg_wdata[0];
        REG_TOTAL:    total_length  <= cfg_wdata[TIME_W-1:0];
        REG_SPEED:    speed_factor  <= cfg_wdata[SPEED_W-1:0];
        REG_MODE:     manual_mode   <= cfg_wdata[MODE_W-1:0];
        REG_MANUAL:   manual_level  <= cfg_wdata[LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  // time advance, saturated at the top of the time range
  assign inc = prod[PROD_W-1:SPEED_FRAC];
  assign sum = {{(PROD_W-SPEED_FRAC-TIME_W+1){1'b0}}, elapsed} + {1'b0, inc};
  assign elapsed_next = (sum[PROD_W-SPEED_FRAC:TIME_W] != '0) ? '1 : sum[TIME_W-1:0];

  // signed compare against total_length - fade_out_time
  assign edge_s  = {1'b0, total_length} - {1'b0, fade_out_time};
  assign to_out  = !hold_at_end && ($signed({1'b0, elapsed}) >= $signed(edge_s));
  assign to_stop = hold_at_end && (elapsed > total_length);

  always_comb begin
    ev_phase  = phase;
    ev_level  = level;
    ev_active = 1'b1;
    ev_div    = 1'b0;
    ev_clamp  = 1'b0;
    ev_a      = elapsed;
    ev_den    = fade_in_time;
    if (phase == PH_IN) begin
      if (elapsed < fade_in_time) begin
        ev_div = 1'b1;
      end else begin
        ev_phase = PH_STEADY;
        ev_level = target_level;
      end
    end
    if (ev_phase == PH_STEADY) begin
      if (to_out) begin
        ev_phase = PH_OUT;
      end else if (to_stop) begin
        ev_phase = PH_STOP;
        ev_clamp = 1'b1;
      end
    end
    // fade-out falls through from steady within the same tick
    if (ev_phase == PH_OUT) begin
      if (elapsed < total_length) begin
        if (fade_out_time == '0) begin
          ev_level = target_level;
        end else begin
          ev_div = 1'b1;
          ev_a   = total_length - elapsed;
          ev_den = fade_out_time;
        end
      end else begin
        ev_level  = '0;
        ev_active = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_in) begin
      req   <= req_t'(in_req);
      delta <= in_delta;
    end
    if (cmd.scale) begin
      prod <= PROD_W'(delta) * PROD_W'(speed_factor);
    end else if (cmd.ramp_mul) begin
      prod <= PROD_W'(ramp_a) * PROD_W'(target_level);
    end
    if (cmd.eval) begin
      ramp_a   <= ev_a;
      ramp_den <= ev_den;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= PH_IDLE;
      elapsed <= '0;
      level   <= '0;
      active  <= 1'b1;
    end else begin
      if (cmd.advance && phase != PH_STOP) begin
        elapsed <= elapsed_next;
      end
      if (cmd.eval) begin
        phase  <= ev_phase;
        level  <= ev_level;
        active <= ev_active;
        if (ev_clamp) begin
          elapsed <= total_length;
        end
      end
      if (cmd.take_q) begin
        level <= div_q;
      end
      if (cmd.load_out && auto && req == REQ_START) begin
        phase   <= PH_IN;
        elapsed <= '0;
        level   <= '0;
        active  <= 1'b1;
      end
    end
  end

  fenv_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (prod),
    .divisor  (ramp_den),
    .busy     (div_busy),
    .quotient (div_q)
  );

  assign stat.auto_tick = auto && (req_t'(in_req) == REQ_TICK);
  assign stat.need_div  = ev_div;
  assign stat.div_busy  = div_busy;

  always_comb begin
    o_applies = manual_mode != MODE_OFF;
    if (!auto) begin
      o_level  = manual_level;
      o_phase  = PH_STEADY;
      o_active = 1'b1;
      o_acc    = 1'b0;
    end else if (req == REQ_START) begin
      o_level  = '0;
      o_phase  = PH_IN;
      o_active = 1'b1;
      o_acc    = 1'b1;
    end else begin
      o_level  = level;
      o_phase  = phase;
      o_active = active;
      o_acc    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data <= {{(OUT_TDATA_W-OUT_FIELD_W){1'b0}},
                   o_applies, o_acc, o_active, o_phase, o_level};
    end
  end

endmodule
